>>> rtl/sra_pkg.sv
// sensor risk alarm package: shared types, constants and the cordic angle table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sra_pkg;

  localparam int TabLen = 24;
  localparam int CordicStepsDef = 16;
  localparam int AngW = 34;       // degrees with 16 fraction bits, signed
  localparam int XyW = 28;        // scaled axis values, signed, with growth
  localparam int AngleMax = 46080;
  localparam logic [AngW-1:0] Deg90Q16 = AngW'(5898240);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CORDIC, ST_ROUND, ST_DIV, ST_RISK, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    LVL_LOW = 2'd0, LVL_MED = 2'd1, LVL_HIGH = 2'd2
  } level_t;

  typedef enum logic [2:0] {
    REG_DRY = 3'd0, REG_WET = 3'd1, REG_TILT = 3'd2,
    REG_BLINK = 3'd3, REG_LOW = 3'd4, REG_HIGH = 3'd5
  } reg_idx_t;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic [22:0] atan_lut(input logic [4:0] i);
    logic [22:0] v;
    begin
      unique case (i)
        5'd0: v = 23'd2949120;  5'd1: v = 23'd1740967; 5'd2: v = 23'd919879;
        5'd3: v = 23'd466945;   5'd4: v = 23'd234379;  5'd5: v = 23'd117304;
        5'd6: v = 23'd58666;    5'd7: v = 23'd29335;   5'd8: v = 23'd14668;
        5'd9: v = 23'd7334;     5'd10: v = 23'd3667;   5'd11: v = 23'd1833;
        5'd12: v = 23'd917;     5'd13: v = 23'd458;    5'd14: v = 23'd229;
        5'd15: v = 23'd115;     5'd16: v = 23'd57;     5'd17: v = 23'd29;
        5'd18: v = 23'd14;      5'd19: v = 23'd7;      5'd20: v = 23'd4;
        5'd21: v = 23'd2;       5'd22: v = 23'd1;      default: v = 23'd0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/sra_cordic.sv
// sensor risk alarm: vectoring cordic, one rotation step per cycle
// depends on sra_pkg
`timescale 1ns / 1ps
`default_nettype none
module sra_cordic import sra_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [15:0] ay,
  input  wire logic signed [15:0] az,
  output logic                    done,
  output logic signed [16:0]      tilt
);
  localparam int NSteps = (CORDIC_STEPS < TabLen) ? CORDIC_STEPS : TabLen;

  logic signed [XyW-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [AngW-1:0] ang_r, ang_nxt;
  logic [4:0]             i_r, i_nxt;
  logic                   busy_r, busy_nxt, done_r, done_nxt, zero_r, zero_nxt;
  logic signed [XyW-1:0]  xs, ys, dx, dy;
  logic signed [AngW-1:0] ar, af;

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; ang_nxt = ang_r; i_nxt = i_r;
    busy_nxt = busy_r; done_nxt = 1'b0; zero_nxt = zero_r;
    xs = XyW'(az) <<< 8;
    ys = XyW'(ay) <<< 8;
    dx = y_r >>> i_r;
    dy = x_r >>> i_r;
    if (start) begin
      // pre-rotation for the left half plane
      zero_nxt = (ay == 16'sd0) && (az == 16'sd0);
      i_nxt = 5'd0; busy_nxt = 1'b1;
      if (az < 0) begin
        if (ay >= 0) begin
          x_nxt = ys; y_nxt = -xs; ang_nxt = Deg90Q16;
        end else begin
          x_nxt = -ys; y_nxt = xs; ang_nxt = -Deg90Q16;
        end
      end else begin
        x_nxt = xs; y_nxt = ys; ang_nxt = '0;
      end
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + dx; y_nxt = y_r - dy;
        ang_nxt = ang_r + AngW'(atan_lut(i_r));
      end else begin
        x_nxt = x_r - dx; y_nxt = y_r + dy;
        ang_nxt = ang_r - AngW'(atan_lut(i_r));
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(NSteps - 1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; ang_r <= ang_nxt; i_r <= i_nxt; zero_r <= zero_nxt;
  end

  // round half up to q8.8 and clamp
  always_comb begin
    ar = (ang_r + AngW'(128)) >>> 8;
    if (zero_r) af = '0;
    else if (ar > AngW'(AngleMax)) af = AngW'(AngleMax);
    else if (ar < -AngW'(AngleMax)) af = -AngW'(AngleMax);
    else af = ar;
  end
  assign tilt = af[16:0];
  assign done = done_r;
endmodule
`default_nettype wire

>>> rtl/sra_divider.sv
// sensor risk alarm: restoring divider, one quotient bit per cycle
// depends on sra_pkg
`timescale 1ns / 1ps
`default_nettype none
module sra_divider import sra_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [25:0] num,
  input  wire logic [15:0] den,
  output logic             done,
  output logic [25:0]      quo
);
  logic [25:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] d_r;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [17:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, q_r[25]} - {2'b0, d_r};
    if (start) begin
      q_nxt = num; rem_nxt = '0; cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in one numerator bit, subtract when it fits
      if (!trial[17]) begin
        rem_nxt = trial[16:0]; q_nxt = {q_r[24:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[15:0], q_r[25]}; q_nxt = {q_r[24:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd25) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt;
    if (start) d_r <= den;
  end

  assign quo = q_r;
  assign done = done_r;
endmodule
`default_nettype wire

>>> rtl/sensor_risk_alarm.sv
// sensor risk alarm top level: config registers, sequencer, risk and alarm logic
// depends on sra_pkg, sra_cordic, sra_divider
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   The input channel (in_valid/in_ready) takes one sample set: moisture, vibration,
//   two accelerometer axes and a millisecond time stamp. The output channel
//   (out_valid/out_ready) returns one result per sample: risk level, alarm drive,
//   risk score in Q1.16 and tilt in signed Q8.8.
//   One sample is processed at a time. From acceptance to out_valid the cordic
//   runs one step a cycle and its result is captured, then three 26-bit divisions
//   for moisture, tilt and vibration run in turn, the three weighted products are
//   accumulated and the output register is loaded. The next sample is taken only
//   once the result has left the output register, so a receiver stall delays it.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the
//   user must make them while the block is idle, which the block does not enforce.
//   Reset loads the default thresholds and calibration, clears the alarm, toggle
//   phase and last toggle time, and empties the output register.
module sensor_risk_alarm import sra_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [9:0]         in_moisture_raw,
  input  wire logic [9:0]         in_vibration_raw,
  input  wire logic signed [15:0] in_accel_y,
  input  wire logic signed [15:0] in_accel_z,
  input  wire logic [31:0]        in_time_ms,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_risk_level,
  output logic                    out_alarm_on,
  output logic [16:0]             out_risk_score,
  output logic signed [16:0]      out_tilt_angle,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [16:0]        cfg_data
);
  // configuration registers
  logic [9:0]  dry_r, wet_r;
  logic [7:0]  tlim_r;
  logic [15:0] blink_r;
  logic [16:0] lowt_r, hight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dry_r <= 10'd200; wet_r <= 10'd800; tlim_r <= 8'd45; blink_r <= 16'd500;
      lowt_r <= 17'd19661; hight_r <= 17'd39322;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DRY:   dry_r <= cfg_data[9:0];
        REG_WET:   wet_r <= cfg_data[9:0];
        REG_TILT:  tlim_r <= cfg_data[7:0];
        REG_BLINK: blink_r <= cfg_data[15:0];
        REG_LOW:   lowt_r <= cfg_data;
        REG_HIGH:  hight_r <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t      st_r, st_nxt;
  logic [9:0]  mraw_r, vraw_r;
  logic [31:0] now_r;
  logic [1:0]  dsel_r, dsel_nxt;   // 0 moisture, 1 tilt, 2 vibration
  logic [16:0] mn_r, tn_r, vn_r, tilt_r;
  logic [34:0] acc_r, acc_nxt;
  logic [31:0] last_r;
  logic        phase_r, alarm_r;
  logic        ov_r;
  logic [1:0]  lvl_r;
  logic [16:0] score_r;

  logic               cs_start, cs_done, dv_start, dv_done;
  logic signed [16:0] cs_tilt;
  logic [25:0]        dv_num, dv_quo;
  logic [15:0]        dv_den;
  logic [16:0]        mag, qclamp;
  logic [16:0]        mul_a;
  logic [14:0]        mul_w;
  logic [31:0]        prod;
  logic [16:0]        risk;
  logic [31:0]        dt;

  sra_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cs_start), .ay(in_accel_y), .az(in_accel_z),
    .done(cs_done), .tilt(cs_tilt)
  );

  sra_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_quo)
  );

  assign in_ready = (st_r == ST_IDLE) && !ov_r;
  assign cs_start = in_valid && in_ready;
  assign mag = tilt_r[16] ? (~tilt_r + 17'd1) : tilt_r;

  // divider operands for the selected normalization
  always_comb begin
    case (dsel_r)
      2'd0: begin
        dv_num = {6'd0, mraw_r - dry_r, 10'd0} << 6;
        dv_den = {6'd0, wet_r - dry_r};
      end
      2'd1: begin
        dv_num = {1'b0, mag, 8'd0};
        dv_den = {8'd0, tlim_r};
      end
      default: begin
        dv_num = {vraw_r, 16'd0};
        dv_den = 16'd1023;
      end
    endcase
  end
  assign qclamp = (dv_quo > 26'd65536) ? 17'd65536 : dv_quo[16:0];

  // one weighted product per cycle
  always_comb begin
    case (dsel_r)
      2'd0:    begin mul_a = mn_r; mul_w = 15'd26214; end
      2'd1:    begin mul_a = tn_r; mul_w = 15'd22938; end
      default: begin mul_a = vn_r; mul_w = 15'd16384; end
    endcase
    prod = mul_a * mul_w;
  end
  assign risk = acc_r[32:16];
  assign dt = now_r - last_r;

  // sequencer: cordic, then one division start per normalization
  always_comb begin
    st_nxt = st_r; dsel_nxt = dsel_r; acc_nxt = acc_r; dv_start = 1'b0;
    unique case (st_r)
      ST_IDLE:   if (cs_start) st_nxt = ST_CORDIC;
      ST_CORDIC: if (cs_done) begin
        dsel_nxt = 2'd0; st_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        dv_start = 1'b1; st_nxt = ST_DIV;
      end
      ST_DIV: if (dv_done) begin
        if (dsel_r == 2'd2) begin
          dsel_nxt = 2'd0; acc_nxt = 35'd32768; st_nxt = ST_RISK;
        end else begin
          dsel_nxt = dsel_r + 2'd1; st_nxt = ST_ROUND;
        end
      end
      ST_RISK: begin
        acc_nxt = acc_r + 35'(prod);
        if (dsel_r == 2'd2) st_nxt = ST_OUT;
        else dsel_nxt = dsel_r + 2'd1;
      end
      ST_OUT: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ov_r <= 1'b0; last_r <= '0; phase_r <= 1'b0; alarm_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_valid && out_ready) ov_r <= 1'b0;
      if (st_r == ST_OUT) begin
        ov_r <= 1'b1;
        score_r <= risk;
        if (risk < lowt_r) begin
          lvl_r <= LVL_LOW; alarm_r <= 1'b0;
        end else if (risk < hight_r) begin
          lvl_r <= LVL_MED;
          if (dt > {16'd0, blink_r}) begin
            last_r <= now_r; phase_r <= ~phase_r; alarm_r <= ~phase_r;
          end
        end else begin
          lvl_r <= LVL_HIGH; alarm_r <= 1'b1;
        end
      end
    end
    dsel_r <= dsel_nxt; acc_r <= acc_nxt;
    if (cs_start) begin
      mraw_r <= in_moisture_raw; vraw_r <= in_vibration_raw; now_r <= in_time_ms;
    end
    if (st_r == ST_CORDIC && cs_done) tilt_r <= cs_tilt;
    // normalized values, special cases override the quotient
    if (st_r == ST_DIV && dv_done) begin
      case (dsel_r)
        2'd0: begin
          if (mraw_r <= dry_r) mn_r <= '0;
          else if (mraw_r >= wet_r) mn_r <= 17'd65536;
          else mn_r <= qclamp;
        end
        2'd1: begin
          if (tlim_r == 8'd0) tn_r <= (mag != 17'd0) ? 17'd65536 : 17'd0;
          else tn_r <= qclamp;
        end
        default: vn_r <= qclamp;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_risk_level = lvl_r;
  assign out_alarm_on = alarm_r;
  assign out_risk_score = score_r;
  assign out_tilt_angle = tilt_r;
endmodule
`default_nettype wire

>>> dv/tb_top.sv
// testbench for sensor_risk_alarm: directed and random sample sets, scoreboard check
// depends on sra_pkg and the sensor_risk_alarm rtl
`timescale 1ns / 1ps
module tb_top;
  import sra_pkg::*;

  localparam int LatencyCycles = CordicStepsDef + 89;
  localparam longint CycleLimit = 3000000;

  typedef struct packed {
    logic [1:0]         level;
    logic               alarm;
    logic [16:0]        score;
    logic signed [16:0] tilt;
  } alarm_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [9:0] in_moisture_raw = '0;
  logic [9:0] in_vibration_raw = '0;
  logic signed [15:0] in_accel_y = '0;
  logic signed [15:0] in_accel_z = '0;
  logic [31:0] in_time_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_risk_level;
  logic out_alarm_on;
  logic [16:0] out_risk_score;
  logic signed [16:0] out_tilt_angle;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  sensor_risk_alarm dut (.*);

  // predictor copy of registers and state
  logic [9:0]  m_dry, m_wet;
  logic [7:0]  t_lim;
  logic [15:0] blink;
  logic [16:0] thr_lo, thr_hi;
  logic [31:0] last_toggle;
  logic        phase, drive;

  alarm_result_t expected_q[$];
  int errors = 0;
  int results_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  logic [31:0] now_ms = 0;
  longint cycles = 0;

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // cycle counter with timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  // atan2(y, z) in signed Q8.8 degrees by vectoring cordic
  function automatic logic signed [16:0] tilt_of(logic signed [15:0] ay,
                                                  logic signed [15:0] az);
    longint x, y, ang, t, dx, dy;
    begin
      if (ay == 0 && az == 0) return '0;
      x = longint'(az) * 256;
      y = longint'(ay) * 256;
      ang = 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; ang = 5898240;
        end else begin
          t = x; x = -y; y = t; ang = -5898240;
        end
      end
      for (int i = 0; i < CordicStepsDef; i++) begin
        dx = fshift(y, i);
        dy = fshift(x, i);
        if (y > 0) begin
          x += dx; y -= dy; ang += longint'(atan_lut(5'(i)));
        end else begin
          x -= dx; y += dy; ang -= longint'(atan_lut(5'(i)));
        end
      end
      ang = fshift(ang + 128, 8);
      if (ang > AngleMax) ang = AngleMax;
      if (ang < -AngleMax) ang = -AngleMax;
      return 17'(ang);
    end
  endfunction

  // risk score, level and alarm drive for one sample set
  function automatic alarm_result_t assess_sample(logic [9:0] mraw, logic [9:0] vraw,
      logic signed [15:0] ay, logic signed [15:0] az, logic [31:0] tnow);
    alarm_result_t r;
    longint tilt, mag, mn, tn, vn, risk;
    begin
      tilt = longint'(tilt_of(ay, az));
      mag = tilt < 0 ? -tilt : tilt;
      if (mraw <= m_dry) mn = 0;
      else if (mraw >= m_wet) mn = 65536;
      else mn = (longint'(mraw - m_dry) << 16) / longint'(m_wet - m_dry);
      if (t_lim == 0) tn = mag != 0 ? 65536 : 0;
      else tn = (mag << 8) / longint'(t_lim);
      if (tn > 65536) tn = 65536;
      vn = (longint'(vraw) << 16) / 1023;
      risk = (26214 * mn + 22938 * tn + 16384 * vn + 32768) >>> 16;
      if (risk < thr_lo) begin
        r.level = LVL_LOW;
        drive = 1'b0;
      end else if (risk < thr_hi) begin
        r.level = LVL_MED;
        if (32'(tnow - last_toggle) > {16'd0, blink}) begin
          last_toggle = tnow;
          phase = ~phase;
          drive = phase;
        end
      end else begin
        r.level = LVL_HIGH;
        drive = 1'b1;
      end
      r.alarm = drive;
      r.score = 17'(risk);
      r.tilt = 17'(tilt);
      return r;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    alarm_result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_risk_level, out_alarm_on, out_risk_score, out_tilt_angle};
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result %p", $time, got);
      end else begin
        want = expected_q.pop_front();
        if (got.level !== want.level) begin
          errors++;
          $display("%0t risk_level exp %0d got %0d", $time, want.level, got.level);
        end
        if (got.alarm !== want.alarm) begin
          errors++;
          $display("%0t alarm_on exp %0d got %0d", $time, want.alarm, got.alarm);
        end
        if (got.score !== want.score) begin
          errors++;
          $display("%0t risk_score exp %0d got %0d", $time, want.score, got.score);
        end
        if (got.tilt !== want.tilt) begin
          errors++;
          $display("%0t tilt_angle exp %0d got %0d", $time, want.tilt, got.tilt);
        end
      end
    end
  end

  // receiver ready with random stalls and long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // send one transaction and record its prediction at acceptance
  task automatic send_sample(logic [9:0] mraw, logic [9:0] vraw,
                             logic signed [15:0] ay, logic signed [15:0] az,
                             logic [31:0] tnow);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_moisture_raw <= mraw;
    in_vibration_raw <= vraw;
    in_accel_y <= ay;
    in_accel_z <= az;
    in_time_ms <= tnow;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(assess_sample(mraw, vraw, ay, az, tnow));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LatencyCycles + 10) @(posedge clk);
  endtask

  // config write, only while idle
  task automatic write_reg(reg_idx_t idx, logic [16:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_DRY:   m_dry = val[9:0];
      REG_WET:   m_wet = val[9:0];
      REG_TILT:  t_lim = val[7:0];
      REG_BLINK: blink = val[15:0];
      REG_LOW:   thr_lo = val;
      REG_HIGH:  thr_hi = val;
      default: ;
    endcase
  endtask

  task automatic set_config(int dry, int wet, int tl, int bl, int lo, int hi);
    write_reg(REG_DRY, 17'(dry));
    write_reg(REG_WET, 17'(wet));
    write_reg(REG_TILT, 17'(tl));
    write_reg(REG_BLINK, 17'(bl));
    write_reg(REG_LOW, 17'(lo));
    write_reg(REG_HIGH, 17'(hi));
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return 16'($urandom_range(64)) - 16'sd32;
      default: return 16'($urandom());
    endcase
  endfunction

  // directed: field extremes, axis quadrants and special cases
  task automatic test_directed();
    send_sample(10'd0, 10'd0, 16'sd0, 16'sd0, 32'd0);
    send_sample(10'd1023, 10'd1023, 16'sh7fff, 16'sh7fff, 32'hffffffff);
    send_sample(10'd500, 10'd0, 16'sd0, -16'sd100, 32'd1000);
    send_sample(10'd500, 10'd300, 16'sh8000, 16'sh8000, 32'd1600);
    send_sample(10'd500, 10'd300, 16'sd100, -16'sd1, 32'd1700);
    send_sample(10'd200, 10'd512, -16'sd1, 16'sd0, 32'd2300);
    send_sample(10'd800, 10'd0, 16'sd0, 16'sh7fff, 32'd2400);
    send_sample(10'd600, 10'd400, 16'sd50, 16'sd100, 32'd3000);
    send_sample(10'd600, 10'd400, 16'sd50, 16'sd100, 32'd3500);
    send_sample(10'd600, 10'd400, 16'sd50, 16'sd100, 32'd3501);
    send_sample(10'd600, 10'd400, 16'sd50, 16'sd100, 32'd10);
    drain();
    // wet not above dry, zero tilt limit, low threshold above high
    set_config(600, 300, 0, 1, 50000, 20000);
    send_sample(10'd600, 10'd10, 16'sd0, 16'sd0, 32'd0);
    send_sample(10'd601, 10'd10, 16'sd1, 16'sd5, 32'd5);
    send_sample(10'd0, 10'd1023, -16'sd7, 16'sd3, 32'd9);
    drain();
    set_config(0, 1023, 180, 65535, 0, 65536);
    send_sample(10'd1023, 10'd1023, 16'sd0, -16'sd5, 32'd0);
    send_sample(10'd0, 10'd0, 16'sd0, 16'sd0, 32'd70000);
    send_sample(10'd512, 10'd512, -16'sd9, -16'sd9, 32'd70001);
    drain();
  endtask

  // random sample sets under one config
  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      now_ms = ($urandom_range(19) == 0) ? $urandom() : now_ms + $urandom_range(900);
      send_sample(10'($urandom()), 10'($urandom()), rand_axis(), rand_axis(), now_ms);
    end
    drain();
  endtask

  task automatic random_config();
    set_config($urandom_range(1023), $urandom_range(1023), $urandom_range(255),
               $urandom_range(65535), $urandom_range(65536), $urandom_range(65536));
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    hold_off = 400;
    test_random(30);
  endtask

  initial begin
    m_dry = 200; m_wet = 800; t_lim = 45; blink = 500;
    thr_lo = 19661; thr_hi = 39322;
    last_toggle = 0; phase = 0; drive = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    set_config(200, 800, 45, 500, 19661, 39322);
    test_random(500);
    send_idle_pct = 83;
    random_config();
    test_random(400);
    send_idle_pct = 0;
    recv_stall_pct = 83;
    set_config(100, 900, 20, 300, 15000, 45000);
    test_random(400);
    send_idle_pct = 13;
    recv_stall_pct = 13;
    random_config();
    test_random(300);
    set_config(300, 700, 90, 200, 20000, 50000);
    test_random(400);
    test_backpressure();
    $display("covered %0d results over several register settings and idle mixes",
             results_seen);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
